@@ rtl/skse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skse_pkg: shared types and constants of the sorted key set engine
// Holds the capacity, field widths, operation and status codes, controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package skse_pkg;

   localparam int CAPACITY = 32;
   localparam int KEY_W    = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      OP_INSERT    = 3'd0,
      OP_DELETE    = 3'd1,
      OP_SEARCH    = 3'd2,
      OP_LIST_ASC  = 3'd3,
      OP_LIST_DESC = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_LIST = 1'b1
   } state_type;

   typedef struct packed {
      logic             single;
      op_type           op;
      logic             list_load;
      logic [IDX_W-1:0] list_idx;
      logic             list_last;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/skse_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skse_req_if / skse_rsp_if: request and response channels
// Valid/ready channels carrying one item each; an item moves at a rising
// clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface skse_req_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       opcode;
   logic signed [skse_pkg::KEY_W-1:0] key;

   modport source (output valid, output opcode, output key, input ready);
   modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface skse_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       status;
   logic signed [skse_pkg::KEY_W-1:0] value;
   logic                             last;

   modport source (output valid, output status, output value, output last, input ready);
   modport sink   (input valid, input status, input value, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/skse_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skse_datapath: key store, parallel compare and response payload
// Keeps the keys sorted in a row of registers, resolves insert, delete and search
// with a less-than and an equality compare per entry, and holds the response payload.
// ----------------------------------------------------------------------------
module skse_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire skse_pkg::cmd_type               cmd,
   input  wire logic signed [skse_pkg::KEY_W-1:0] key,
   output skse_pkg::sts_type                    sts,
   output logic [2:0]                           rsp_status,
   output logic signed [skse_pkg::KEY_W-1:0]    rsp_value,
   output logic                                 rsp_last
);

   localparam int CAP = skse_pkg::CAPACITY;
   localparam int KW  = skse_pkg::KEY_W;
   localparam int CW  = skse_pkg::CNT_W;

   logic signed [KW-1:0] keys_ff  [CAP];
   logic signed [KW-1:0] keys_in  [CAP];
   logic signed [KW-1:0] up_keys  [CAP];
   logic signed [KW-1:0] dn_keys  [CAP];
   logic [CW-1:0]        count_ff, count_in;
   logic [CAP-1:0]       lt, eq, lt_prev;
   logic                 found, empty, full;
   skse_pkg::status_type status;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic signed [KW-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Entries below the fill count are valid and ascending, so lt is a
   // thermometer code whose edge is the insert position.
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         lt[i] = (CW'(i) < count_ff) && (keys_ff[i] < key);
         eq[i] = (CW'(i) < count_ff) && (keys_ff[i] == key);
      end
      lt_prev[0] = 1'b0;
      up_keys[0] = key;
      dn_keys[CAP-1] = keys_ff[CAP-1];
      for (int i = 1; i < CAP; i++) begin
         lt_prev[i]   = lt[i-1];
         up_keys[i]   = keys_ff[i-1];
         dn_keys[i-1] = keys_ff[i];
      end
   end

   assign found = |eq;
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(CAP));

   always_comb begin
      status   = skse_pkg::ST_OK;
      count_in = count_ff;
      for (int i = 0; i < CAP; i++) begin
         keys_in[i] = keys_ff[i];
      end
      if (cmd.single) begin
         case (cmd.op)
            skse_pkg::OP_INSERT: begin
               if (found) begin
                  status = skse_pkg::ST_DUP;
               end else if (full) begin
                  status = skse_pkg::ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  for (int i = 0; i < CAP; i++) begin
                     keys_in[i] = lt[i] ? keys_ff[i] : (lt_prev[i] || i == 0) ? key : up_keys[i];
                  end
               end
            end
            skse_pkg::OP_DELETE: begin
               if (empty) begin
                  status = skse_pkg::ST_EMPTY;
               end else if (!found) begin
                  status = skse_pkg::ST_NOTFOUND;
               end else begin
                  count_in = count_ff - CW'(1);
                  for (int i = 0; i < CAP; i++) begin
                     keys_in[i] = lt[i] ? keys_ff[i] : dn_keys[i];
                  end
               end
            end
            skse_pkg::OP_SEARCH: begin
               if (empty) begin
                  status = skse_pkg::ST_EMPTY;
               end else if (!found) begin
                  status = skse_pkg::ST_NOTFOUND;
               end
            end
            default: begin
               // A listing only comes here when the set is empty.
               status = skse_pkg::ST_EMPTY;
            end
         endcase
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.single) begin
         rsp_status_in = status;
         rsp_value_in  = '0;
         rsp_last_in   = 1'b1;
      end else if (cmd.list_load) begin
         rsp_status_in = skse_pkg::ST_OK;
         rsp_value_in  = keys_ff[cmd.list_idx];
         rsp_last_in   = cmd.list_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAP; i++) begin
         keys_ff[i] <= keys_in[i];
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign sts.count  = count_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/skse_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skse_ctrl: request sequencing and listing walk
// Accepts requests, issues single operations to the datapath, steps through
// the store for listings and owns the response valid flag.
// ----------------------------------------------------------------------------
module skse_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire logic [2:0]              req_opcode,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   input  wire skse_pkg::sts_type       sts,
   output skse_pkg::cmd_type            cmd
);

   localparam int IW = skse_pkg::IDX_W;
   localparam int CW = skse_pkg::CNT_W;

   skse_pkg::state_type state_ff, state_in;
   skse_pkg::op_type    op;
   logic [IW-1:0]       step_ff, step_in;
   logic                desc_ff, desc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_busy, accept, step_last;

   assign op        = skse_pkg::op_type'(req_opcode);
   assign rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign accept    = req_valid && req_ready;
   assign step_last = (CW'(step_ff) == sts.count - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skse_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         desc_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         desc_ff      <= desc_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      desc_in       = desc_ff;
      rsp_valid_in  = rsp_busy;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.op        = op;
      case (state_ff)
         skse_pkg::S_IDLE: begin
            req_ready = !rsp_busy;
            if (accept) begin
               case (op)
                  skse_pkg::OP_INSERT, skse_pkg::OP_DELETE, skse_pkg::OP_SEARCH: begin
                     cmd.single   = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  skse_pkg::OP_LIST_ASC, skse_pkg::OP_LIST_DESC: begin
                     if (sts.count == '0) begin
                        cmd.single   = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = skse_pkg::S_LIST;
                        step_in  = '0;
                        desc_in  = (op == skse_pkg::OP_LIST_DESC);
                     end
                  end
                  default: begin
                     // Undefined opcodes are dropped without a response.
                  end
               endcase
            end
         end
         skse_pkg::S_LIST: begin
            if (!rsp_busy) begin
               cmd.list_load = 1'b1;
               cmd.list_last = step_last;
               cmd.list_idx  = desc_ff ? IW'(sts.count - CW'(1) - CW'(step_ff)) : step_ff;
               rsp_valid_in  = 1'b1;
               step_in       = step_ff + IW'(1);
               if (step_last) begin
                  state_in = skse_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = skse_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == skse_pkg::S_IDLE)
      else $error("request accepted outside idle");

   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == skse_pkg::S_LIST |-> sts.count != '0 && CW'(step_ff) < sts.count)
      else $error("listing walk beyond fill count");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.list_load && cmd.list_last |=> state_ff == skse_pkg::S_IDLE)
      else $error("listing did not end after last item");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.single || cmd.list_load) |-> !rsp_busy)
      else $error("response overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/sorted_key_set_engine.sv @@
`default_nettype none
// Insert, delete and search: the response is valid in the cycle after acceptance.
// Listing of N keys: N responses; acceptance enters the listing state, which reads the
// register row into the response register one key per cycle unless the response stalls;
// a new request can be taken at the edge that takes the only or last response; a stalled
// response holds off the request side. An empty listing gives one response, like a single
// operation. Reset clears the fill count and control state; key registers are not reset.
// ----------------------------------------------------------------------------
// sorted_key_set_engine: bounded sorted set of distinct signed keys
// Top level joining the controller and the datapath to the two channels.
// ----------------------------------------------------------------------------
module sorted_key_set_engine (
   input  wire     clock,
   input  wire     reset,
   skse_req_if.sink   req_ch,
   skse_rsp_if.source rsp_ch
);

   skse_pkg::cmd_type cmd;
   skse_pkg::sts_type sts;

   skse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_opcode (req_ch.opcode),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   skse_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .key        (req_ch.key),
      .sts        (sts),
      .rsp_status (rsp_ch.status),
      .rsp_value  (rsp_ch.value),
      .rsp_last   (rsp_ch.last)
   );

endmodule

`default_nettype wire

@@ test/tb_sorted_key_set_engine.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_key_set_engine: self-checking bench for the sorted key set engine
// A short table of directed requests covers the empty set, the key extremes,
// duplicates, misses and the unused opcodes. A fill-to-capacity burst and
// random epochs that lean toward filling, draining or mixing the set follow.
// Each response is checked against a behavioral copy of the set, or against the status
// a typed directed row gives. Both channels idle at random, and the response side holds
// off once for a long stretch so that the engine stalls its request channel.
// ----------------------------------------------------------------------------
module tb_sorted_key_set_engine;
   timeunit 1ns;
   timeprecision 1ps;
   import skse_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int RESET_CYCLES = 12;
   localparam int ITEM_TARGET  = 480;
   localparam int EPOCH_LEN    = 40;
   localparam int POOL_SIZE    = 48;
   localparam int HOLD_CYCLES  = 150;
   localparam int HOLD_AFTER   = 120;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;
   localparam int IDLE_LIMIT   = 2000;
   localparam int PRINT_LIMIT  = 30;

   localparam logic [2:0] OP_RSVD_LO  = 3'd5;
   localparam logic [2:0] OP_RSVD_MID = 3'd6;
   localparam logic [2:0] OP_RSVD_HI  = 3'd7;

   localparam logic signed [KEY_W-1:0] KEY_MIN  = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KEY_ZERO = 32'sh0000_0000;
   localparam logic signed [KEY_W-1:0] KEY_NEG1 = 32'shFFFF_FFFF;

   typedef struct {
      status_type              status;
      logic signed [KEY_W-1:0] value;
      logic                    last;
   } set_rsp_type;

   typedef struct {
      logic [2:0]              op;
      logic signed [KEY_W-1:0] key;
      bit                      typed;
      status_type              want;
   } stim_row_type;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   skse_req_if req_ch ();
   skse_rsp_if rsp_ch ();

   sorted_key_set_engine DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Behavioral copy of the set: ascending keys in entries below set_count.
   logic signed [KEY_W-1:0] set_keys [CAPACITY];
   int                      set_count = 0;
   set_rsp_type             expected_rsps [$];

   logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

   int  error_count     = 0;
   int  items_sent      = 0;
   int  live_items      = 0;
   int  lists_sent      = 0;
   int  results_checked = 0;
   int  full_rejects    = 0;
   int  dup_rejects     = 0;
   int  times_full      = 0;
   int  times_emptied   = 0;
   bit  hold_active     = 1'b0;
   bit  hold_done       = 1'b0;
   int  idle_cycles     = 0;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // Applies one request to the set copy and returns the responses it causes.
   function automatic void set_model_step(input logic [2:0] op,
                                          input logic signed [KEY_W-1:0] key,
                                          ref set_rsp_type res[$]);
      set_rsp_type r;
      int          pos;
      bool_hit:
      begin
      end
      res = {};
      pos = 0;
      while (pos < set_count && set_keys[pos] < key)
         pos++;
      r.value = '0;
      r.last  = 1'b1;
      case (op)
         OP_INSERT: begin
            if (pos < set_count && set_keys[pos] == key) begin
               r.status = ST_DUP;
            end else if (set_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (int i = set_count; i > pos; i--)
                  set_keys[i] = set_keys[i-1];
               set_keys[pos] = key;
               set_count++;
               r.status = ST_OK;
            end
            res.push_back(r);
         end
         OP_DELETE, OP_SEARCH: begin
            if (set_count == 0) begin
               r.status = ST_EMPTY;
            end else if (pos >= set_count || set_keys[pos] != key) begin
               r.status = ST_NOTFOUND;
            end else begin
               r.status = ST_OK;
               if (op == OP_DELETE) begin
                  for (int i = pos; i + 1 < set_count; i++)
                     set_keys[i] = set_keys[i+1];
                  set_count--;
               end
            end
            res.push_back(r);
         end
         OP_LIST_ASC, OP_LIST_DESC: begin
            if (set_count == 0) begin
               r.status = ST_EMPTY;
               res.push_back(r);
            end else begin
               for (int i = 0; i < set_count; i++) begin
                  r.status = ST_OK;
                  r.value  = (op == OP_LIST_ASC) ? set_keys[i] : set_keys[set_count-1-i];
                  r.last   = (i + 1 == set_count);
                  res.push_back(r);
               end
            end
         end
         default: begin
            // Unused opcodes are dropped without a response.
         end
      endcase
   endfunction

   function automatic int idle_len();
      int r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(50, 20);
   endfunction

   // Offers one item, waits for it to be taken, records what it should cause.
   task automatic drive_item(input stim_row_type row, input int gap);
      set_rsp_type res [$];
      set_rsp_type fixed;
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= row.op;
      req_ch.key    <= row.key;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      set_model_step(row.op, row.key, res);
      items_sent++;
      if (row.op == OP_LIST_ASC || row.op == OP_LIST_DESC)
         lists_sent++;
      if (res.size() != 0) begin
         if (res[0].status == ST_FULL) full_rejects++;
         if (res[0].status == ST_DUP) dup_rejects++;
         if (row.op == OP_INSERT && res[0].status == ST_OK && set_count == CAPACITY)
            times_full++;
         if (row.op == OP_DELETE && res[0].status == ST_OK && set_count == 0)
            times_emptied++;
      end
      if (row.typed) begin
         fixed.status = row.want;
         fixed.value  = '0;
         fixed.last   = 1'b1;
         res = {fixed};
      end
      foreach (res[i])
         expected_rsps.push_back(res[i]);
      if (gap > 0) begin
         req_ch.valid  <= 1'b0;
         req_ch.opcode <= 3'($urandom);
         req_ch.key    <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response checker.
   always @(posedge clock) begin : rsp_check
      set_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         results_checked++;
         if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("unexpected response status=%0d value=%0d last=%0b",
                                      rsp_ch.status, rsp_ch.value, rsp_ch.last));
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %s",
                                         rsp_ch.status, want.status.name()));
            if (rsp_ch.value !== want.value)
               report_mismatch($sformatf("value %0d, expected %0d",
                                         rsp_ch.value, want.value));
            if (rsp_ch.last !== want.last)
               report_mismatch($sformatf("last %b, expected %b",
                                         rsp_ch.last, want.last));
         end
      end
   end

   // Ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin : watchdog
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                   (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] Timeout: no item moved for %0d cycles, %0d responses pending",
                     $realtime, IDLE_LIMIT, expected_rsps.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Response side: random stalls, plus one long hold-off once traffic is going.
   initial begin : rsp_sink
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (!hold_done && items_sent >= HOLD_AFTER) begin
            hold_done   = 1'b1;
            hold_active = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(40, 1)) @(posedge clock);
         if ($urandom_range(3) != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (idle_len() + 1) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      stim_row_type directed_rows [$];
      stim_row_type row;
      mix_type      mix;
      bit           steady;
      int           pick;
      int           kp;
      int           ins_pct;
      int           del_pct;
      int           hit_pct;

      req_ch.valid  = 1'b0;
      req_ch.opcode = OP_INSERT;
      req_ch.key    = KEY_ZERO;

      foreach (key_pool[i])
         key_pool[i] = $urandom;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = KEY_ZERO;
      key_pool[3] = KEY_NEG1;

      // Empty set first, then the extremes, duplicates, misses and unused codes.
      directed_rows.push_back('{OP_SEARCH,    KEY_ZERO, 1'b1, ST_EMPTY});
      directed_rows.push_back('{OP_DELETE,    KEY_MAX,  1'b1, ST_EMPTY});
      directed_rows.push_back('{OP_LIST_ASC,  KEY_ZERO, 1'b1, ST_EMPTY});
      directed_rows.push_back('{OP_LIST_DESC, KEY_NEG1, 1'b1, ST_EMPTY});
      directed_rows.push_back('{OP_INSERT,    KEY_MIN,  1'b1, ST_OK});
      directed_rows.push_back('{OP_INSERT,    KEY_MAX,  1'b1, ST_OK});
      directed_rows.push_back('{OP_INSERT,    KEY_ZERO, 1'b1, ST_OK});
      directed_rows.push_back('{OP_INSERT,    KEY_MAX,  1'b1, ST_DUP});
      directed_rows.push_back('{OP_SEARCH,    KEY_MIN,  1'b1, ST_OK});
      directed_rows.push_back('{OP_SEARCH,    KEY_NEG1, 1'b1, ST_NOTFOUND});
      directed_rows.push_back('{OP_RSVD_LO,   KEY_MAX,  1'b0, ST_OK});
      directed_rows.push_back('{OP_RSVD_MID,  KEY_MIN,  1'b0, ST_OK});
      directed_rows.push_back('{OP_RSVD_HI,   KEY_NEG1, 1'b0, ST_OK});
      directed_rows.push_back('{OP_LIST_ASC,  KEY_MAX,  1'b0, ST_OK});
      directed_rows.push_back('{OP_LIST_DESC, KEY_MIN,  1'b0, ST_OK});
      directed_rows.push_back('{OP_DELETE,    KEY_ZERO, 1'b1, ST_OK});
      directed_rows.push_back('{OP_DELETE,    KEY_ZERO, 1'b1, ST_NOTFOUND});
      directed_rows.push_back('{OP_INSERT,    KEY_NEG1, 1'b1, ST_OK});
      directed_rows.push_back('{OP_INSERT,    KEY_MIN,  1'b1, ST_DUP});
      directed_rows.push_back('{OP_LIST_ASC,  KEY_ZERO, 1'b0, ST_OK});
      directed_rows.push_back('{OP_LIST_DESC, KEY_ZERO, 1'b0, ST_OK});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         drive_item(directed_rows[i], idle_len());
         if (directed_rows[i].op <= OP_LIST_DESC)
            live_items++;
      end

      // Fill to capacity, then hit the full set with a new key and a stored one.
      row.typed = 1'b0;
      row.want  = ST_OK;
      row.op    = OP_INSERT;
      while (set_count < CAPACITY) begin
         row.key = $urandom;
         drive_item(row, idle_len());
         live_items++;
      end
      row.key = $urandom;
      drive_item(row, idle_len());
      row.key = set_keys[$urandom_range(CAPACITY - 1)];
      drive_item(row, idle_len());
      row.op = OP_LIST_ASC;
      drive_item(row, idle_len());
      row.op = OP_LIST_DESC;
      drive_item(row, idle_len());
      live_items += 4;

      for (int e = 0; live_items < ITEM_TARGET; e++) begin
         mix    = mix_type'($urandom_range(2));
         steady = (e % 4 == 3);
         case (mix)
            MIX_FILL:  begin ins_pct = 55; del_pct = 15; hit_pct = 25; end
            MIX_DRAIN: begin ins_pct = 15; del_pct = 55; hit_pct = 60; end
            default:   begin ins_pct = 35; del_pct = 30; hit_pct = 30; end
         endcase
         repeat (EPOCH_LEN) begin
            pick = $urandom_range(99);
            if (pick < 4)
               row.op = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
            else if (pick < 4 + ins_pct)
               row.op = OP_INSERT;
            else if (pick < 4 + ins_pct + del_pct)
               row.op = OP_DELETE;
            else if (pick < 19 + ins_pct + del_pct)
               row.op = OP_SEARCH;
            else
               row.op = pick[0] ? OP_LIST_ASC : OP_LIST_DESC;
            kp = $urandom_range(99);
            if (set_count > 0 && kp < hit_pct)
               row.key = set_keys[$urandom_range(set_count - 1)];
            else if (kp < 80)
               row.key = key_pool[$urandom_range(POOL_SIZE - 1)];
            else
               row.key = $urandom;
            drive_item(row, (steady || hold_active) ? 0 : idle_len());
            if (row.op <= OP_LIST_DESC)
               live_items++;
         end
      end

      req_ch.valid <= 1'b0;
      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests (%0d listings) and %0d checked responses.",
               items_sent, lists_sent, results_checked);
      $display("Set filled %0d times and emptied %0d times; %0d full and %0d duplicate rejects.",
               times_full, times_emptied, full_rejects, dup_rejects);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/skse_pkg.sv
rtl/skse_if.sv
rtl/skse_datapath.sv
rtl/skse_ctrl.sv
rtl/sorted_key_set_engine.sv
test/tb_sorted_key_set_engine.sv
